[sv/fstat_pkg.sv]
`timescale 1ns / 1ps
package fstat_pkg;

  localparam int TOP_CAP = 128;
  localparam int TOP_IW = 8;
  localparam int TAIL_SW = 47;
  localparam logic [63:0] FPS_SCALE = 64'd65536000000000;
  localparam int TAIL_DIV_A = 1000;
  localparam int TAIL_DIV_B = 10000;

  // reciprocals for the tail lengths: floor(x / div) = (x * RECIP) >> SH for x < 2^17
  localparam logic [17:0] RECIP_A = 18'd134218;
  localparam int RECIP_A_SH = 27;
  localparam logic [17:0] RECIP_B = 18'd107375;
  localparam int RECIP_B_SH = 30;

  localparam logic [1:0] REG_MAX_SAMPLES = 2'd0;
  localparam logic [1:0] REG_WINDOW_NS = 2'd1;
  localparam logic [1:0] REG_REFRESH_NS = 2'd2;

  typedef enum logic [2:0] {
    DIV_MEAN,
    DIV_MFPS,
    DIV_PEAK,
    DIV_LA,
    DIV_LB
  } div_op_t;

  typedef struct packed {
    logic    capture;
    logic    append;
    logic    pop;
    logic    scan_init;
    logic    scan_step;
    logic    sum_step;
    logic    div_start;
    div_op_t div_op;
    logic    clear_cache;
    logic    commit;
    logic    out_load;
  } fstat_cmd_t;

  typedef struct packed {
    logic drop;
    logic full;
    logic held_zero;
    logic evict;
    logic refresh_due;
    logic div_done;
    logic scan_done;
    logic sum_done;
    logic out_free;
  } fstat_status_t;

endpackage

[sv/frame_time_window_stats_core.sv]
`timescale 1ns / 1ps
// Sliding-window frame time statistics. Each word in carries a frame interval and
// start time; a zero or negative interval is taken and dropped with no word out.
// Every other word yields one word out after the append and eviction check, with a
// read and pop first when the store is full and a read and pop per evicted entry; the
// next word can be taken in the cycle after the word out is loaded. A recompute adds
// five passes of the shared 64-step divider, a scan of the window memory (one read
// port) over the n held intervals, and a pass that totals the tail list (k the longer
// tail, at most 128).
module frame_time_window_stats_core import fstat_pkg::*; #(
  parameter int HISTORY_DEPTH = 32768,
  parameter int TAIL_MIN_A = 8,
  parameter int TAIL_MIN_B = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [39:0]   cfg_data,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [103:0]  s_axis_tdata,  // interval_ns[40:0], start_ns[103:41]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // window_count, mean_interval_ns, mean_fps_q16, peak_fps_q16,
  // low_tenth_pct_fps_q16, low_hundredth_pct_fps_q16, stats_revision
  output logic [271:0]  m_axis_tdata,
  output logic [1:0]    m_axis_tuser   // stats_valid[0], refreshed[1]
);

  fstat_cmd_t    cmd;
  fstat_status_t status;

  assign cfg_ready = 1'b1;

  fstat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fstat_datapath #(
    .DEPTH      (HISTORY_DEPTH),
    .TAIL_MIN_A (TAIL_MIN_A),
    .TAIL_MIN_B (TAIL_MIN_B)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

[sv/fstat_div.sv]
`timescale 1ns / 1ps
module fstat_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [55:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] dvd;
  logic [55:0] dvs;
  logic [55:0] rem;
  logic [56:0] sh;
  logic        fits;

  assign sh = {rem, dvd[63]};
  assign fits = sh >= {1'b0, dvs};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        dvd <= dividend;
        dvs <= divisor;
        rem <= '0;
      end else if (busy) begin
        // one quotient bit per cycle, quotient shifts into dvd
        rem <= fits ? 56'(sh - {1'b0, dvs}) : sh[55:0];
        dvd <= {dvd[62:0], fits};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/fstat_datapath.sv]
`timescale 1ns / 1ps
module fstat_datapath import fstat_pkg::*; #(
  parameter int DEPTH = 32768,
  parameter int TAIL_MIN_A = 8,
  parameter int TAIL_MIN_B = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [39:0]   cfg_data,
  input  logic [103:0]  in_data,
  input  fstat_cmd_t    cmd,
  output fstat_status_t status,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [271:0]  out_data,
  output logic [1:0]    out_user
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [15:0] max_samples;
  logic [39:0] window_ns;
  logic [39:0] refresh_ns;

  logic [39:0] cur_ival;
  logic [62:0] cur_start;

  logic [39:0] ival_mem [DEPTH];
  logic [62:0] start_mem [DEPTH];
  logic [39:0] ival_q;
  logic [62:0] start_q;
  logic [AW-1:0] rd_addr;

  logic [AW-1:0] oldest;
  logic [AW-1:0] wr_ptr;
  logic [CW-1:0] held;
  logic [55:0]   wsum;
  logic [62:0]   last_ref;
  logic          ever;
  logic [31:0]   rev_ctr;
  logic          refreshed;

  logic          cvalid;
  logic [39:0]   c_mean;
  logic [45:0]   c_mfps;
  logic [45:0]   c_peak;
  logic [45:0]   c_la;
  logic [45:0]   c_lb;
  logic [31:0]   c_rev;

  logic [AW-1:0] scan_ptr;
  logic [CW-1:0] scan_cnt;
  logic          pipe_v;
  logic [39:0]   minv;
  logic [39:0]   top [TOP_CAP];
  logic [39:0]   up [TOP_CAP];
  logic [39:0]   dn [TOP_CAP];
  logic [TOP_IW-1:0] ka, kb, kmax, sum_idx;
  logic [TAIL_SW-1:0] sa, sb;

  logic [16:0]   ka_num, kb_num;
  logic [34:0]   ka_prod, kb_prod;

  logic [CW-1:0] cap;
  logic          sum_done;

  logic [16:0]   mul_k;
  logic [62:0]   prod;
  logic [63:0]   div_dvd;
  logic [55:0]   div_dvs;
  logic          div_done;
  logic [63:0]   div_q;
  div_op_t       lat_op;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  function automatic logic [TOP_IW-1:0] tail_clamp(input logic [63:0] q,
                                                   input logic [CW-1:0] n,
                                                   input int unsigned mn);
    logic [63:0] k;
    k = q;
    if (k < 64'(mn)) k = 64'(mn);
    if (k < 64'd1) k = 64'd1;
    if (k > 64'(n)) k = 64'(n);
    if (k > 64'(TOP_CAP)) k = 64'(TOP_CAP);
    return TOP_IW'(k);
  endfunction

  assign cap = (32'(max_samples) > DEPTH) ? CW'(DEPTH) : CW'(max_samples);
  assign kmax = (ka > kb) ? ka : kb;
  assign sum_done = (sum_idx == kmax);
  assign rd_addr = cmd.scan_step ? scan_ptr : oldest;

  // ceil(n / 1000) and ceil(n / 10000) by reciprocal multiply
  assign ka_num = 17'(held) + 17'(TAIL_DIV_A - 1);
  assign kb_num = 17'(held) + 17'(TAIL_DIV_B - 1);
  assign ka_prod = 35'(ka_num) * 35'(RECIP_A);
  assign kb_prod = 35'(kb_num) * 35'(RECIP_B);

  assign status.drop = (in_data[40:0] == 41'd0) || in_data[40];
  assign status.full = (held == CW'(DEPTH));
  assign status.held_zero = (held == '0);
  assign status.evict = (held > cap) ||
                        (({1'b0, start_q} + {24'd0, window_ns}) < {1'b0, cur_start});
  assign status.refresh_due = !ever ||
      ((cur_start >= last_ref) && ((cur_start - last_ref) >= {23'd0, refresh_ns}));
  assign status.div_done = div_done;
  assign status.scan_done = (scan_cnt == held) && !pipe_v;
  assign status.sum_done = sum_done;
  assign status.out_free = !out_valid || out_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_samples <= 16'd24000;
      window_ns <= 40'd10000000000;
      refresh_ns <= 40'd250000000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_SAMPLES: max_samples <= cfg_data[15:0];
        REG_WINDOW_NS:   window_ns <= cfg_data;
        REG_REFRESH_NS:  refresh_ns <= cfg_data;
        default: ;
      endcase
    end
  end

  // window stores
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      ival_mem[wr_ptr] <= cur_ival;
      start_mem[wr_ptr] <= cur_start;
    end
    ival_q <= ival_mem[rd_addr];
    start_q <= start_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_ival <= in_data[39:0];
      cur_start <= in_data[103:41];
    end
  end

  // window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      wr_ptr <= '0;
      held <= '0;
      wsum <= '0;
    end else if (cmd.pop) begin
      oldest <= ptr_inc(oldest);
      held <= held - 1'b1;
      wsum <= wsum - {16'd0, ival_q};
    end else if (cmd.append) begin
      wr_ptr <= ptr_inc(wr_ptr);
      held <= held + 1'b1;
      wsum <= wsum + {16'd0, cur_ival};
    end
  end

  // scan: registered read, sorted top list as a row of insert cells
  always_comb begin
    up[0] = '1;
    dn[TOP_CAP-1] = '0;
    for (int j = 1; j < TOP_CAP; j++) up[j] = top[j-1];
    for (int j = 0; j < TOP_CAP - 1; j++) dn[j] = top[j+1];
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_ptr <= oldest;
      scan_cnt <= '0;
      pipe_v <= 1'b0;
      minv <= '1;
      sum_idx <= '0;
      sa <= '0;
      sb <= '0;
      for (int j = 0; j < TOP_CAP; j++) top[j] <= '0;
    end else begin
      pipe_v <= cmd.scan_step && (scan_cnt != held);
      if (cmd.scan_step && (scan_cnt != held)) begin
        scan_ptr <= ptr_inc(scan_ptr);
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (pipe_v) begin
        if (ival_q < minv) minv <= ival_q;
        for (int j = 0; j < TOP_CAP; j++) begin
          if (top[j] < ival_q) top[j] <= (up[j] >= ival_q) ? ival_q : up[j];
        end
      end else if (cmd.sum_step && !sum_done) begin
        // shift the list out through the head
        if (sum_idx < ka) sa <= sa + {7'd0, top[0]};
        if (sum_idx < kb) sb <= sb + {7'd0, top[0]};
        sum_idx <= sum_idx + 1'b1;
        for (int j = 0; j < TOP_CAP; j++) top[j] <= dn[j];
      end
    end
  end

  // tail lengths, held is stable for the whole recompute
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      ka <= tail_clamp(64'(ka_prod[34:RECIP_A_SH]), held, TAIL_MIN_A);
      kb <= tail_clamp(64'(kb_prod[34:RECIP_B_SH]), held, TAIL_MIN_B);
    end
  end

  // divider operands
  assign prod = 63'(FPS_SCALE) * 63'(mul_k);

  always_comb begin
    mul_k = '0;
    div_dvd = '0;
    div_dvs = 56'd1;
    case (cmd.div_op)
      DIV_MEAN: begin
        div_dvd = {8'd0, wsum};
        div_dvs = 56'(held);
      end
      DIV_MFPS: begin
        mul_k = 17'(held);
        div_dvd = {1'b0, prod};
        div_dvs = wsum;
      end
      DIV_PEAK: begin
        div_dvd = FPS_SCALE;
        div_dvs = {16'd0, minv};
      end
      DIV_LA: begin
        mul_k = 17'(ka);
        div_dvd = {1'b0, prod};
        div_dvs = {9'd0, sa};
      end
      DIV_LB: begin
        mul_k = 17'(kb);
        div_dvd = {1'b0, prod};
        div_dvs = {9'd0, sb};
      end
      default: ;
    endcase
  end

  fstat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) lat_op <= cmd.div_op;
  end

  // cached statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      last_ref <= '0;
      ever <= 1'b0;
      rev_ctr <= '0;
      refreshed <= 1'b0;
      cvalid <= 1'b0;
      c_mean <= '0;
      c_mfps <= '0;
      c_peak <= '0;
      c_la <= '0;
      c_lb <= '0;
      c_rev <= '0;
    end else begin
      if (cmd.capture) refreshed <= 1'b0;
      if (cmd.clear_cache) begin
        cvalid <= 1'b0;
        c_mean <= '0;
        c_mfps <= '0;
        c_peak <= '0;
        c_la <= '0;
        c_lb <= '0;
        c_rev <= '0;
      end
      if (div_done) begin
        case (lat_op)
          DIV_MEAN: c_mean <= div_q[39:0];
          DIV_MFPS: c_mfps <= div_q[45:0];
          DIV_PEAK: c_peak <= div_q[45:0];
          DIV_LA:   c_la <= div_q[45:0];
          DIV_LB:   c_lb <= div_q[45:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        rev_ctr <= rev_ctr + 32'd1;
        c_rev <= rev_ctr + 32'd1;
        cvalid <= 1'b1;
        ever <= 1'b1;
        last_ref <= cur_start;
        refreshed <= 1'b1;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {c_rev, c_lb, c_la, c_peak, c_mfps, c_mean, 16'(held)};
      out_user <= {refreshed, cvalid};
    end
  end

endmodule

[sv/fstat_ctrl.sv]
`timescale 1ns / 1ps
module fstat_ctrl import fstat_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fstat_status_t status,
  output fstat_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FULL_RD,
    S_FULL_POP,
    S_APPEND,
    S_EV_RD,
    S_EV_CHK,
    S_DECIDE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SCAN_INIT,
    S_SCAN,
    S_SUM,
    S_COMMIT,
    S_OUT
  } state_t;

  state_t  state;
  div_op_t op;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.div_op = op;
    case (state)
      S_IDLE:      cmd.capture = in_valid && !status.drop;
      S_FULL_POP:  cmd.pop = 1'b1;
      S_APPEND:    cmd.append = 1'b1;
      S_EV_CHK:    cmd.pop = status.evict;
      S_DECIDE:    cmd.clear_cache = status.held_zero;
      S_DIV_GO:    cmd.div_start = 1'b1;
      S_SCAN_INIT: cmd.scan_init = 1'b1;
      S_SCAN:      cmd.scan_step = 1'b1;
      S_SUM:       cmd.sum_step = 1'b1;
      S_COMMIT:    cmd.commit = 1'b1;
      S_OUT:       cmd.out_load = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= DIV_MEAN;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && !status.drop) state <= status.full ? S_FULL_RD : S_APPEND;
        end
        S_FULL_RD:  state <= S_FULL_POP;
        S_FULL_POP: state <= S_APPEND;
        S_APPEND:   state <= S_EV_RD;
        S_EV_RD:    state <= status.held_zero ? S_DECIDE : S_EV_CHK;
        S_EV_CHK:   state <= status.evict ? S_EV_RD : S_DECIDE;
        S_DECIDE: begin
          if (status.held_zero) begin
            state <= S_OUT;
          end else if (status.refresh_due) begin
            state <= S_SCAN_INIT;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (status.div_done) begin
            case (op)
              DIV_MEAN: begin op <= DIV_MFPS; state <= S_DIV_GO;    end
              DIV_MFPS: begin op <= DIV_PEAK; state <= S_DIV_GO;    end
              DIV_PEAK: begin op <= DIV_LA;   state <= S_DIV_GO;    end
              DIV_LA:   begin op <= DIV_LB;   state <= S_DIV_GO;    end
              default:  begin                 state <= S_COMMIT;    end
            endcase
          end
        end
        S_SCAN_INIT: state <= S_SCAN;
        S_SCAN:      if (status.scan_done) state <= S_SUM;
        S_SUM: begin
          if (status.sum_done) begin
            op <= DIV_MEAN;
            state <= S_DIV_GO;
          end
        end
        S_COMMIT: state <= S_OUT;
        S_OUT:    if (status.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule
